>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned IN_W     = 48;
  localparam int unsigned OUT_W    = 40;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

  typedef struct packed {
    logic               enq;
    logic               deq;
    logic [VALUE_W-1:0] value;
  } spq_ctl_t;

endpackage

>>> sv/spq_cell.sv
module spq_cell #(
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                          clk,
  input  spq_pkg::spq_ctl_t             ctl,
  input  logic [PRIORITY_BITS-1:0]      new_prio,
  input  logic                          occupied,
  input  logic                          left_keep,
  input  logic [spq_pkg::VALUE_W-1:0]   left_value,
  input  logic [PRIORITY_BITS-1:0]      left_prio,
  input  logic [spq_pkg::VALUE_W-1:0]   right_value,
  input  logic [PRIORITY_BITS-1:0]      right_prio,
  output logic                          keep,
  output logic [spq_pkg::VALUE_W-1:0]   value,
  output logic [PRIORITY_BITS-1:0]      prio
);

  logic [spq_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [PRIORITY_BITS-1:0]    prio_r, prio_nxt;

  // stored entries ahead of the insertion point stay put
  assign keep = occupied && (prio_r >= new_prio);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl.enq && !keep) begin
      if (left_keep) begin
        value_nxt = ctl.value;
        prio_nxt  = new_prio;
      end else begin
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end
    end else if (ctl.deq) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;

endmodule

>>> sv/stable_priority_queue.sv
// A result is registered and appears on out_* in the cycle after its item is accepted.
// Throughput: one item per cycle; every cell of the chain compares and shifts
// in the same cycle. in_tready drops while a result waits with out_tready low.
// Reset (rst_n, synchronous, active low) empties the queue and the output
// register; cell contents are not cleared.
module stable_priority_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] command, [32:1] item_value, [40:33] item_priority, [47:41] zero
  input  logic [spq_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] out_value, [33:32] status, [38:34] occupancy, [39] zero
  output logic [spq_pkg::OUT_W-1:0]   out_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic                          in_cmd;
  logic [spq_pkg::VALUE_W-1:0]   in_value;
  logic [7:0]                    in_prio8;
  logic [31:0]                   prio_ext;
  logic [PRIORITY_BITS-1:0]      new_prio;

  assign in_cmd   = in_tdata[0];
  assign in_value = in_tdata[32:1];
  assign in_prio8 = in_tdata[40:33];
  assign prio_ext = {24'd0, in_prio8};
  assign new_prio = prio_ext[PRIORITY_BITS-1:0];

  logic                          out_valid_r, out_valid_nxt;
  logic [spq_pkg::VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic [spq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [spq_pkg::OCC_W-1:0]     out_occ_r, out_occ_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [31:0]                   count_ext;

  logic in_acc, is_full, is_empty;
  spq_pkg::spq_ctl_t ctl;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);

  assign ctl.enq   = in_acc && (in_cmd == spq_pkg::CMD_ENQ) && !is_full;
  assign ctl.deq   = in_acc && (in_cmd == spq_pkg::CMD_DEQ) && !is_empty;
  assign ctl.value = in_value;

  logic [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0]    cell_prio  [DEPTH];
  logic [DEPTH-1:0]            cell_keep;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic                        occ, lkeep;
    logic [spq_pkg::VALUE_W-1:0] lval, rval;
    logic [PRIORITY_BITS-1:0]    lpri, rpri;

    assign occ = count_r > IDX;

    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lval  = in_value;
      assign lpri  = new_prio;
    end else begin : g_mid
      assign lkeep = cell_keep[i-1];
      assign lval  = cell_value[i-1];
      assign lpri  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rval = '0;
      assign rpri = '0;
    end else begin : g_inner
      assign rval = cell_value[i+1];
      assign rpri = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_prio   (new_prio),
      .occupied   (occ),
      .left_keep  (lkeep),
      .left_value (lval),
      .left_prio  (lpri),
      .right_value(rval),
      .right_prio (rpri),
      .keep       (cell_keep[i]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_occ_nxt   = count_ext[spq_pkg::OCC_W-1:0];
      unique case (in_cmd)
        spq_pkg::CMD_ENQ: begin
          out_value_nxt  = '0;
          out_status_nxt = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end
        spq_pkg::CMD_DEQ: begin
          out_value_nxt  = is_empty ? spq_pkg::EMPTY_VALUE : cell_value[0];
          out_status_nxt = is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
        end
        default: begin
          out_value_nxt  = '0;
          out_status_nxt = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_occ_r, out_status_r, out_value_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.enq |=> count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not grow the queue");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status_r == spq_pkg::ST_EMPTY) |-> out_value_r == spq_pkg::EMPTY_VALUE)
    else $error("empty dequeue without all-ones value");

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_occ_r == $past(count_ext[spq_pkg::OCC_W-1:0]))
    else $error("reported occupancy differs from count");
`endif

endmodule

>>> verif/spq_checker.sv
module spq_checker #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  // [0] command, [32:1] item_value, [40:33] item_priority, [47:41] zero
  input  logic [spq_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // [31:0] out_value, [33:32] status, [38:34] occupancy, [39] zero
  input  logic [spq_pkg::OUT_W-1:0] out_tdata,
  output int unsigned               error_total,
  output int unsigned               outstanding
);

  // first member lands in the top bits, so value ends up lowest as on out_tdata
  typedef struct packed {
    logic [spq_pkg::OCC_W-1:0]    occupancy;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::VALUE_W-1:0]  value;
  } queue_result_t;

  logic [spq_pkg::VALUE_W-1:0] held_value [DEPTH];
  logic [PRIORITY_BITS-1:0]    held_prio  [DEPTH];
  int unsigned                 held_count = 0;
  int unsigned                 errs = 0;
  queue_result_t               awaited_results [$];

  function automatic queue_result_t advance_shadow_queue(
    input logic                        cmd,
    input logic [spq_pkg::VALUE_W-1:0] value,
    input logic [PRIORITY_BITS-1:0]    prio
  );
    queue_result_t r;
    int unsigned   slot;
    bit            placed;
    r.value  = '0;
    r.status = spq_pkg::ST_OK;
    if (cmd == spq_pkg::CMD_ENQ) begin
      if (held_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        slot   = held_count;
        placed = 1'b0;
        for (int k = 0; k < held_count; k++) begin
          if (!placed && held_prio[k] < prio) begin
            slot   = k;
            placed = 1'b1;
          end
        end
        for (int k = held_count; k > slot; k--) begin
          held_value[k] = held_value[k-1];
          held_prio[k]  = held_prio[k-1];
        end
        held_value[slot] = value;
        held_prio[slot]  = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.value  = spq_pkg::EMPTY_VALUE;
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.value = held_value[0];
      for (int k = 1; k < held_count; k++) begin
        held_value[k-1] = held_value[k];
        held_prio[k-1]  = held_prio[k];
      end
      held_count--;
    end
    r.occupancy = spq_pkg::OCC_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      held_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(
          advance_shadow_queue(in_tdata[0], in_tdata[32:1],
                               PRIORITY_BITS'(in_tdata[40:33])));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(queue_result_t)-1:0];
        if (awaited_results.size() == 0) begin
          $error("out_tdata: result with no item pending, got %h", out_tdata);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (got.value !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, got.value);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            errs++;
          end
        end
      end
    end
    outstanding <= awaited_results.size();
    error_total <= errs;
  end

endmodule

>>> verif/testbench.sv
module testbench;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned RUN_ITEMS     = 600;
  localparam int unsigned CALM_ITEMS    = 100;
  localparam int unsigned RUN_LIMIT     = 200000;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [spq_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [spq_pkg::OUT_W-1:0] out_tdata;

  int unsigned error_total;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_priority_queue #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spq_checker #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) queue_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_total (error_total),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_op(
    input logic                         cmd,
    input logic [spq_pkg::VALUE_W-1:0]  value,
    input logic [7:0]                   prio
  );
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, prio, value, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_prio(input bit narrow);
    if (narrow) return 8'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned enq_pct;
    bit          narrow;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct   = 30;
    stall_pct = 30;
    send_op(spq_pkg::CMD_DEQ, 32'hDEAD_BEEF, 8'hA5);
    send_op(spq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 8'd0);
    send_op(spq_pkg::CMD_ENQ, 32'h8000_0000, 8'd255);
    send_op(spq_pkg::CMD_ENQ, 32'h0000_0000, 8'd128);
    send_op(spq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 8'd255);
    send_op(spq_pkg::CMD_ENQ, 32'h0000_0001, 8'd0);
    send_op(spq_pkg::CMD_ENQ, 32'h5555_5555, 8'd1);
    send_op(spq_pkg::CMD_ENQ, 32'hAAAA_AAAA, 8'd254);
    for (int i = 0; i < 9; i++) begin
      send_op(spq_pkg::CMD_ENQ, 32'h0101_0101 * (i + 2), 8'((i % 3) * 64 + 1));
    end
    send_op(spq_pkg::CMD_ENQ, 32'h1234_5678, 8'd255);
    repeat (5) send_op(spq_pkg::CMD_DEQ, $urandom(), 8'($urandom_range(0, 255)));

    // phases lean toward filling, draining or balance
    sent = 0;
    while (sent < RUN_ITEMS) begin
      run_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      narrow = $urandom_range(0, 1);
      if (sent + CALM_ITEMS >= RUN_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 10 * $urandom_range(0, 4);
        stall_pct = 10 * $urandom_range(0, 4);
      end
      for (int i = 0; i < run_len && sent < RUN_ITEMS; i++) begin
        send_op(($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                pick_value(), pick_prio(narrow));
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
verif/spq_checker.sv
verif/testbench.sv
